/* rtl/pnk_pkg.sv */
`default_nettype none

package pnk_pkg;

  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned RAW_W    = 28;
  localparam int unsigned AMP_W    = 18;
  localparam int unsigned UNI_W    = 17;
  localparam int unsigned BIP_W    = 18;
  localparam int unsigned SEED_W   = 32;
  localparam int unsigned LCG_W    = 32;
  localparam int unsigned IDX_W    = 2;

  localparam logic [LCG_W-1:0]  LCG_MUL    = 32'd196314165;
  localparam logic [LCG_W-1:0]  LCG_ADD    = 32'd907633515;
  localparam logic [SEED_W-1:0] SEED_RESET = 32'd22222;
  localparam logic [UNI_W-1:0]  AMP_ONE    = 17'd65536;

  typedef enum logic [IDX_W-1:0] {
    RegSeed      = 2'd0,
    RegFixedAmp  = 2'd1,
    RegAmpSource = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    SrcFixed    = 2'd0,
    SrcUnipolar = 2'd1,
    SrcBipolar  = 2'd2
  } amp_src_e;

endpackage

`default_nettype wire

/* rtl/pnk_ram.sv */
`default_nettype none

module pnk_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/pnk_scale.sv */
`default_nettype none

module pnk_scale
  import pnk_pkg::*;
#(
  parameter int unsigned ROWS        = 12,
  parameter int unsigned RANDOM_BITS = 24,
  localparam int unsigned SumW = RANDOM_BITS + $clog2(ROWS + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic signed [SumW-1:0]     sum_i,
  input  logic signed [AMP_W-1:0]    amp_i,
  input  logic                       take_i,
  output logic                       valid_o,
  output logic signed [SAMPLE_W-1:0] sample_o
);

  localparam int unsigned PW    = SumW + AMP_W;
  localparam int unsigned UW    = SAMPLE_W + $clog2(ROWS + 1);
  localparam int unsigned Shift = RANDOM_BITS - 8;
  localparam int unsigned Div   = ROWS + 1;

  localparam logic [63:0] RecipWide = (64'd1 << 32) / Div;
  localparam logic [31:0] Recip     = RecipWide[31:0];
  localparam logic [63:0] Bias64    = (64'd1 << (SAMPLE_W - 1)) * Div;
  localparam logic [63:0] Hi64      = Bias64 - 64'd1;
  localparam logic [63:0] Lo64      = 64'd0 - Bias64;
  localparam logic signed [PW-1:0] HiLim = Hi64[PW-1:0];
  localparam logic signed [PW-1:0] LoLim = Lo64[PW-1:0];
  localparam logic signed [PW-1:0] Bias  = Bias64[PW-1:0];
  localparam logic [UW-1:0]        DivU  = Bias64[UW-1:0] >> (SAMPLE_W - 1);
  localparam logic [SAMPLE_W-1:0]  Off   = {1'b1, {(SAMPLE_W - 1){1'b0}}};

  logic                  v1_q, v2_q;
  logic signed [PW-1:0]  p_q;
  logic [UW-1:0]         u_q, q0_q;
  logic                  move;
  logic signed [PW-1:0]  t, tc, u_full;
  logic [UW+31:0]        prod;
  logic [UW-1:0]         r, q;

  assign move = v1_q && (!v2_q || take_i);

  always_comb begin
    t = p_q >>> Shift;
    if (t > HiLim) begin
      tc = HiLim;
    end else if (t < LoLim) begin
      tc = LoLim;
    end else begin
      tc = t;
    end
    u_full = tc + Bias;
    prod   = u_full[UW-1:0] * Recip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (start_i) begin
        v1_q <= 1'b1;
      end else if (move) begin
        v1_q <= 1'b0;
      end
      if (move) begin
        v2_q <= 1'b1;
      end else if (take_i) begin
        v2_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      p_q <= sum_i * amp_i;
    end
    if (move) begin
      u_q  <= u_full[UW-1:0];
      q0_q <= prod[UW+31:32];
    end
  end

  // correct the reciprocal estimate by at most one
  always_comb begin
    r = u_q - (q0_q * DivU);
    q = q0_q + UW'(r >= DivU);
  end

  assign valid_o  = v2_q;
  assign sample_o = $signed(q[SAMPLE_W-1:0] - Off);

endmodule

`default_nettype wire

/* rtl/pink_noise_generator.sv */
// Channel  Dir  Handshake                     Beat
// s_axis   in   s_axis_tvalid/s_axis_tready   unipolar_gain, bipolar_mod
// m_axis   out  m_axis_tvalid/m_axis_tready   sample, raw_sum
// cfg      in   cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// One beat at a time: an accepted beat reaches the output register through the row
// memory read, the two chained generator steps and the three-step scaler.
// The next input beat is taken the cycle after the result is loaded, while it waits.
// Reset and a seed write clear the row valid flags at once; no clearing pass.
// A stalled output holds the finished sample in the scaler until the register frees.
`default_nettype none

module pink_noise_generator
  import pnk_pkg::*;
#(
  parameter int unsigned ROWS        = 12,
  parameter int unsigned RANDOM_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // unipolar_gain[16:0], bipolar_mod[34:17], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // sample[23:0], raw_sum[51:24], zero pad
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned AddrW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned SumW  = RANDOM_BITS + $clog2(ROWS + 1);
  localparam int unsigned ExtW  = (SumW > RAW_W) ? SumW : RAW_W;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StRow   = 5'b00010,
    StSum   = 5'b00100,
    StScale = 5'b01000,
    StWait  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [UNI_W-1:0]        fixed_amp_q;
  logic [1:0]              amp_src_q;
  logic [LCG_W-1:0]        lcg_q, lcg_d, lcg_next;
  logic signed [SumW-1:0]  total_q, total_d;
  logic [ROWS-1:0]         tick_q, tick_d, tick_next;
  logic [ROWS-1:0]         row_valid_q, row_valid_d;
  logic [AddrW-1:0]        row_addr_q, row_sel;
  logic                    tick_nz_q;
  logic signed [AMP_W-1:0] amp_q, amp_d;
  logic signed [SumW-1:0]  sum_q, sum_d;
  logic                    m_valid_q;
  logic [SAMPLE_W-1:0]     sample_q;
  logic [RAW_W-1:0]        raw_q;

  logic                       in_acc, seed_wr, out_free, load_out;
  logic                       ram_we;
  logic [RANDOM_BITS-1:0]     ram_rdata;
  logic signed [SumW-1:0]     rnd_ext, old_ext;
  logic [BIP_W-1:0]           bip;
  logic signed [BIP_W:0]      bip_sum;
  logic                       sc_start, sc_valid;
  logic signed [SAMPLE_W-1:0] sc_sample;
  logic signed [ExtW-1:0]     sum_ext;
  logic                       found;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign seed_wr       = cfg_valid_i && (cfg_index_i == RegSeed);
  assign out_free      = !m_valid_q || m_axis_tready;
  assign load_out      = (state_q == StWait) && sc_valid && out_free;
  assign sc_start      = (state_q == StScale);

  assign lcg_next  = lcg_q * LCG_MUL + LCG_ADD;
  assign tick_next = tick_q + 1'b1;
  assign rnd_ext   = SumW'($signed(lcg_q[LCG_W-1 -: RANDOM_BITS]));
  assign old_ext   = row_valid_q[row_addr_q] ? SumW'($signed(ram_rdata)) : '0;
  assign ram_we    = (state_q == StRow) && tick_nz_q;
  assign sum_ext   = ExtW'(sum_q);

  // trailing zero count picks the row
  always_comb begin
    found   = 1'b0;
    row_sel = '0;
    for (int i = 0; i < ROWS; i++) begin
      if (!found && tick_next[i]) begin
        row_sel = AddrW'(i);
        found   = 1'b1;
      end
    end
  end

  always_comb begin
    bip     = s_axis_tdata[UNI_W +: BIP_W];
    bip_sum = $signed({bip[BIP_W-1], bip}) + $signed({2'b00, AMP_ONE});
    case (amp_src_q)
      SrcUnipolar: amp_d = $signed({1'b0, s_axis_tdata[UNI_W-1:0]});
      SrcBipolar:  amp_d = bip_sum[BIP_W:1];
      default:     amp_d = $signed({1'b0, fixed_amp_q});
    endcase
  end

  always_comb begin
    state_d     = state_q;
    lcg_d       = lcg_q;
    total_d     = total_q;
    tick_d      = tick_q;
    row_valid_d = row_valid_q;
    sum_d       = sum_q;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          tick_d  = tick_next;
          if (tick_next != '0) begin
            lcg_d = lcg_next;
          end
          state_d = StRow;
        end
      end
      StRow: begin
        if (tick_nz_q) begin
          total_d                 = total_q - old_ext + rnd_ext;
          row_valid_d[row_addr_q] = 1'b1;
        end
        lcg_d   = lcg_next;
        state_d = StSum;
      end
      StSum: begin
        sum_d   = total_q + rnd_ext;
        state_d = StScale;
      end
      StScale: begin
        state_d = StWait;
      end
      StWait: begin
        if (load_out) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
    if (seed_wr) begin
      lcg_d       = cfg_data_i;
      total_d     = '0;
      tick_d      = '0;
      row_valid_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      fixed_amp_q <= AMP_ONE;
      amp_src_q   <= SrcFixed;
      lcg_q       <= SEED_RESET;
      total_q     <= '0;
      tick_q      <= '0;
      row_valid_q <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      lcg_q       <= lcg_d;
      total_q     <= total_d;
      tick_q      <= tick_d;
      row_valid_q <= row_valid_d;
      if (cfg_valid_i && (cfg_index_i == RegFixedAmp)) begin
        fixed_amp_q <= cfg_data_i[UNI_W-1:0];
      end
      if (cfg_valid_i && (cfg_index_i == RegAmpSource)) begin
        amp_src_q <= cfg_data_i[1:0];
      end
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      amp_q      <= amp_d;
      row_addr_q <= row_sel;
      tick_nz_q  <= (tick_next != '0);
    end
    sum_q <= sum_d;
    if (load_out) begin
      sample_q <= sc_sample;
      raw_q    <= sum_ext[RAW_W-1:0];
    end
  end

  pnk_ram #(
    .Width (RANDOM_BITS),
    .Depth (ROWS)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (row_addr_q),
    .wdata_i (lcg_q[LCG_W-1 -: RANDOM_BITS]),
    .raddr_i (row_sel),
    .rdata_o (ram_rdata)
  );

  pnk_scale #(
    .ROWS        (ROWS),
    .RANDOM_BITS (RANDOM_BITS)
  ) u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (sc_start),
    .sum_i    (sum_q),
    .amp_i    (amp_q),
    .take_i   (load_out),
    .valid_o  (sc_valid),
    .sample_o (sc_sample)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0000, raw_q, sample_q};

endmodule

`default_nettype wire

/* tb/pink_noise_generator_tb.sv */
`timescale 1ns / 1ps

module pink_noise_generator_tb;
  import pnk_pkg::*;

  localparam int unsigned ROWS_N     = 12;
  localparam int unsigned DROP_BITS  = 8;
  localparam longint      SCALE_DEN  = longint'(ROWS_N + 1) * longint'(AMP_ONE);
  localparam longint      SAMPLE_MAX = 64'sd8388607;
  localparam longint      SAMPLE_MIN = -64'sd8388608;
  localparam int          SETTLE_CYC = 12;
  localparam int          CYCLE_CAP  = 1000000;
  localparam logic [IDX_W-1:0] RegSpare = 2'd3;
  localparam logic [1:0]       SrcSpare = 2'd3;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] audio;
    logic signed [RAW_W-1:0]    raw_sum;
  } noise_beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  logic [31:0]       seed_reg;
  logic [UNI_W-1:0]  fixed_amp_reg;
  logic [1:0]        amp_src_reg;
  logic [LCG_W-1:0]  lcg_state;
  int                row_bank [ROWS_N];
  longint            row_total;
  logic [ROWS_N-1:0] tick_count;

  noise_beat_t expected_q[$];
  int          fail_count;
  int          cycle_count;
  int          send_idle_pct;
  int          stall_pct;

  pink_noise_generator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void clear_generator();
    lcg_state  = seed_reg;
    row_total  = 0;
    tick_count = '0;
    foreach (row_bank[i]) row_bank[i] = 0;
  endfunction

  function automatic int draw_random();
    lcg_state = lcg_state * LCG_MUL + LCG_ADD;
    return $signed(lcg_state) >>> DROP_BITS;
  endfunction

  function automatic noise_beat_t predict_noise(input logic [UNI_W-1:0] uni,
                                                input logic [BIP_W-1:0] bip);
    int                zeros;
    int                fresh;
    logic [ROWS_N-1:0] t;
    longint            total_sum;
    longint            amp;
    longint            num;
    longint            quo;
    noise_beat_t       beat;
    tick_count = tick_count + 1'b1;
    if (tick_count != '0) begin
      t     = tick_count;
      zeros = 0;
      while (!t[0] && zeros < ROWS_N - 1) begin
        t = t >> 1;
        zeros++;
      end
      row_total       -= row_bank[zeros];
      fresh            = draw_random();
      row_total       += fresh;
      row_bank[zeros]  = fresh;
    end
    total_sum = row_total + draw_random();
    case (amp_src_reg)
      SrcUnipolar: amp = longint'(uni);
      SrcBipolar:  amp = (longint'($signed(bip)) + longint'(AMP_ONE)) >>> 1;
      default:     amp = longint'(fixed_amp_reg);
    endcase
    num = total_sum * amp;
    quo = num / SCALE_DEN;
    if ((num % SCALE_DEN) != 0 && num < 0) quo--;
    if (quo > SAMPLE_MAX) quo = SAMPLE_MAX;
    if (quo < SAMPLE_MIN) quo = SAMPLE_MIN;
    beat.audio   = quo[SAMPLE_W-1:0];
    beat.raw_sum = total_sum[RAW_W-1:0];
    return beat;
  endfunction

  function automatic logic [UNI_W-1:0] pick_gain();
    case ($urandom_range(5))
      0:       return '0;
      1:       return AMP_ONE;
      2:       return '1;
      3:       return UNI_W'($urandom);
      default: return UNI_W'($urandom_range(AMP_ONE));
    endcase
  endfunction

  function automatic logic [BIP_W-1:0] pick_mod();
    case ($urandom_range(5))
      0:       return -BIP_W'(AMP_ONE);
      1:       return BIP_W'(AMP_ONE);
      2:       return BIP_W'($urandom);
      default: return BIP_W'($urandom_range(2 * AMP_ONE) - AMP_ONE);
    endcase
  endfunction

  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    wait (expected_q.size() == 0);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic push_gain(input logic [UNI_W-1:0] uni, input logic [BIP_W-1:0] bip);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata  = {5'b0, bip, uni};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q.push_back(predict_noise(uni, bip));
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] value);
    settle();
    cfg_index_i = idx;
    cfg_data_i  = value;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegSeed: begin
        seed_reg = value;
        clear_generator();
      end
      RegFixedAmp:  fixed_amp_reg = value[UNI_W-1:0];
      RegAmpSource: amp_src_reg   = value[1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic test_reset_state();
    repeat (3) push_gain(AMP_ONE, '0);
  endtask

  task automatic test_amplitude_modes();
    write_reg(RegFixedAmp, 32'd0);
    push_gain(pick_gain(), pick_mod());
    write_reg(RegFixedAmp, {15'h7FFF, 17'h1FFFF});
    repeat (2) push_gain(pick_gain(), pick_mod());
    write_reg(RegAmpSource, 32'(SrcSpare));
    push_gain('0, '0);
    write_reg(RegAmpSource, 32'(SrcUnipolar));
    push_gain('0, '1);
    push_gain(AMP_ONE, '0);
    push_gain('1, '0);
    write_reg(RegAmpSource, 32'(SrcBipolar));
    push_gain('0, -BIP_W'(AMP_ONE));
    push_gain('1, BIP_W'(AMP_ONE));
    push_gain('0, '0);
    push_gain('0, '1);
    push_gain('0, 18'h1FFFF);
    push_gain('1, 18'h20000);
    write_reg(RegSpare, $urandom);
    push_gain(pick_gain(), pick_mod());
  endtask

  task automatic test_seed_reload();
    write_reg(RegAmpSource, 32'(SrcFixed));
    write_reg(RegFixedAmp, 32'(AMP_ONE));
    write_reg(RegSeed, 32'd0);
    repeat (2) push_gain(pick_gain(), pick_mod());
    write_reg(RegSeed, 32'hFFFF_FFFF);
    repeat (2) push_gain(pick_gain(), pick_mod());
  endtask

  task automatic test_long_run();
    write_reg(RegSeed, $urandom);
    write_reg(RegAmpSource, 32'(SrcUnipolar));
    repeat (500) push_gain(pick_gain(), pick_mod());
  endtask

  task automatic run_random_phase(input int idle_pct, input int stall, input int beats);
    int done;
    done          = 0;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    while (done < beats) begin
      if ($urandom_range(3) == 0) write_reg(RegSeed, $urandom);
      if ($urandom_range(1) == 0) write_reg(RegFixedAmp, {15'($urandom), pick_gain()});
      write_reg(RegAmpSource, {30'($urandom), 2'($urandom_range(3))});
      repeat ($urandom_range(40, 140)) begin
        push_gain(pick_gain(), pick_mod());
        done++;
        if ($urandom_range(59) == 0) settle();
      end
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(0, 0, 260);
    run_random_phase(59, 0, 260);
    run_random_phase(0, 59, 260);
    run_random_phase(14, 14, 260);
    send_idle_pct = 0;
    stall_pct     = 0;
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready = ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    noise_beat_t want;
    noise_beat_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.audio   = m_axis_tdata[23:0];
      got.raw_sum = m_axis_tdata[51:24];
      if (expected_q.size() == 0) begin
        $error("unexpected beat: sample %0d, raw_sum %0d", got.audio, got.raw_sum);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (got.audio !== want.audio) begin
          $error("sample: expected %0d, actual %0d", want.audio, got.audio);
          fail_count++;
        end
        if (got.raw_sum !== want.raw_sum) begin
          $error("raw_sum: expected %0d, actual %0d", want.raw_sum, got.raw_sum);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("pink_noise_generator: mismatch");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    fail_count    = 0;
    cycle_count   = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    seed_reg      = SEED_RESET;
    fixed_amp_reg = AMP_ONE;
    amp_src_reg   = SrcFixed;
    clear_generator();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_amplitude_modes();
    test_seed_reload();
    test_long_run();
    test_random_traffic();

    settle();
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("pink_noise_generator: match");
    end else begin
      $display("pink_noise_generator: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/pnk_pkg.sv
rtl/pnk_ram.sv
rtl/pnk_scale.sv
rtl/pink_noise_generator.sv
tb/pink_noise_generator_tb.sv
